// File: hdl/tccw_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the text console cell writer.
// Used by tccw_ctrl, tccw_checker, text_console_cell_writer and tb_top; depends on nothing.
package tccw_pkg;

    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 24;

    localparam int ACTION_W = 3;
    localparam int CHAR_W   = 8;
    localparam int ATTR_W   = 8;
    localparam int SIGN_W   = 2;
    localparam int COL_W    = 7;
    localparam int ROW_W    = 5;
    localparam int CELL_W   = CHAR_W + ATTR_W;

    localparam logic [ACTION_W-1:0] ACT_PUT_CHAR  = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_BACKSPACE = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_SCROLL    = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_PUT_AT    = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_CLEAR     = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_READ_CELL = 3'd5;

    localparam logic [SIGN_W-1:0] SCROLL_UP = 2'b01;

    localparam logic [CHAR_W-1:0] SPACE_CHAR    = 8'h20;
    localparam logic [CHAR_W-1:0] NEWLINE_CHAR  = 8'h0A;
    localparam logic [ATTR_W-1:0] GREY_ON_BLACK = 8'h07;
    localparam logic [CELL_W-1:0] BLANK_CELL    = {GREY_ON_BLACK, SPACE_CHAR};
    localparam logic [ATTR_W-1:0] TEXT_COLOR_RST = 8'h07;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COPY,
        ST_FILL,
        ST_BLANK,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [ROW_W-1:0]    row;
        logic [COL_W-1:0]    col;
        logic [SIGN_W-1:0]   scroll_sign;
        logic [ATTR_W-1:0]   color_attr;
        logic [CHAR_W-1:0]   char_code;
        logic [ACTION_W-1:0] action;
    } t_item;

    typedef struct packed {
        logic [ATTR_W-1:0] cell_color;
        logic [CHAR_W-1:0] cell_char;
        logic [COL_W-1:0]  cursor_col;
        logic [ROW_W-1:0]  cursor_row;
    } t_result;

endpackage

// File: hdl/tccw_ram.sv
`timescale 1ns / 1ps
// Generic single-clock RAM: one write port and one read port, registered read.
// No dependencies.
module tccw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1920
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // Read data holds until the next read.
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/tccw_ctrl.sv
`timescale 1ns / 1ps
// Sequencer of the console: cursor, action decode, row copy and fill sweeps.
// Depends on tccw_pkg; drives the ports of one tccw_ram.
module tccw_ctrl #(
    parameter int COLUMNS = tccw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tccw_pkg::ROWS_DEF,
    localparam int CELLS  = COLUMNS * ROWS,
    localparam int AW     = $clog2(CELLS)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  tccw_pkg::t_item             i_item,
    input  logic [tccw_pkg::ATTR_W-1:0] i_text_color,
    output logic                        o_res_valid,
    input  logic                        i_res_ready,
    output tccw_pkg::t_result           o_res,
    output logic                        o_we,
    output logic [AW-1:0]               o_waddr,
    output logic [tccw_pkg::CELL_W-1:0] o_wdata,
    output logic                        o_re,
    output logic [AW-1:0]               o_raddr,
    input  logic [tccw_pkg::CELL_W-1:0] i_rdata
);

    localparam int RW = $clog2(ROWS);
    localparam int CW = $clog2(COLUMNS);
    localparam logic [AW-1:0] NCOPY      = AW'(CELLS - COLUMNS);
    localparam logic [AW-1:0] LAST_CELL  = AW'(CELLS - 1);
    localparam logic [AW-1:0] LAST_ROW0  = AW'(COLUMNS - 1);
    localparam logic [AW-1:0] LAST_BASE  = AW'((ROWS - 1) * COLUMNS);
    localparam logic [AW-1:0] COL_STEP   = AW'(COLUMNS);
    localparam logic [AW-1:0] DOWN_SRC0  = AW'(CELLS - 1 - COLUMNS);
    localparam logic [RW-1:0] LAST_ROW   = RW'(ROWS - 1);
    localparam logic [CW-1:0] LAST_COL   = CW'(COLUMNS - 1);

    tccw_pkg::t_state r_state, n_state;
    logic [RW-1:0]    r_row, n_row;
    logic [CW-1:0]    r_col, n_col;
    logic [AW-1:0]    r_cnt, n_cnt;
    logic [AW-1:0]    r_end, n_end;
    logic [AW-1:0]    r_wdst, n_wdst;
    logic             r_wvld, n_wvld;
    logic             r_up, n_up;
    logic             r_bs, n_bs;
    logic             r_nores, n_nores;
    logic             r_rd_hit, n_rd_hit;
    logic [tccw_pkg::CELL_W-1:0] r_fill, n_fill;

    logic [AW-1:0] cur_addr;
    logic [AW-1:0] item_addr;
    logic          item_in_range;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            // The reset clearing pass runs as a full-screen fill.
            r_state  <= tccw_pkg::ST_FILL;
            r_row    <= '0;
            r_col    <= '0;
            r_cnt    <= '0;
            r_end    <= LAST_CELL;
            r_wvld   <= 1'b0;
            r_up     <= 1'b0;
            r_bs     <= 1'b0;
            r_nores  <= 1'b1;
            r_rd_hit <= 1'b0;
            r_fill   <= tccw_pkg::BLANK_CELL;
        end else begin
            r_state  <= n_state;
            r_row    <= n_row;
            r_col    <= n_col;
            r_cnt    <= n_cnt;
            r_end    <= n_end;
            r_wvld   <= n_wvld;
            r_up     <= n_up;
            r_bs     <= n_bs;
            r_nores  <= n_nores;
            r_rd_hit <= n_rd_hit;
            r_fill   <= n_fill;
        end
        r_wdst <= n_wdst;
    end

    assign cur_addr      = AW'(32'(r_row) * COLUMNS + 32'(r_col));
    assign item_addr     = AW'(32'(i_item.row) * COLUMNS + 32'(i_item.col));
    assign item_in_range = (32'(i_item.col) < COLUMNS) && (32'(i_item.row) < ROWS);

    always_comb begin
        n_state  = r_state;
        n_row    = r_row;
        n_col    = r_col;
        n_cnt    = r_cnt;
        n_end    = r_end;
        n_wdst   = r_wdst;
        n_wvld   = r_wvld;
        n_up     = r_up;
        n_bs     = r_bs;
        n_nores  = r_nores;
        n_rd_hit = r_rd_hit;
        n_fill   = r_fill;
        o_ready     = 1'b0;
        o_res_valid = 1'b0;
        o_we        = 1'b0;
        o_waddr     = r_cnt;
        o_wdata     = r_fill;
        o_re        = 1'b0;
        o_raddr     = '0;

        case (r_state)
            tccw_pkg::ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_state  = tccw_pkg::ST_DONE;
                    n_rd_hit = 1'b0;
                    n_cnt    = '0;
                    n_wvld   = 1'b0;
                    case (i_item.action)
                        tccw_pkg::ACT_PUT_CHAR: begin
                            if (i_item.char_code != tccw_pkg::NEWLINE_CHAR) begin
                                o_we    = 1'b1;
                                o_waddr = cur_addr;
                                o_wdata = {i_text_color, i_item.char_code};
                            end
                            if (i_item.char_code == tccw_pkg::NEWLINE_CHAR
                                || r_col == LAST_COL) begin
                                n_col = '0;
                                if (r_row == LAST_ROW) begin
                                    n_state = tccw_pkg::ST_COPY;
                                    n_up    = 1'b1;
                                end else begin
                                    n_row = r_row + RW'(1);
                                end
                            end else begin
                                n_col = r_col + CW'(1);
                            end
                        end
                        tccw_pkg::ACT_BACKSPACE: begin
                            if (r_col == '0 && r_row == '0) begin
                                // Top-left: scroll down, then blank the end of row 0.
                                n_col   = LAST_COL;
                                n_state = tccw_pkg::ST_COPY;
                                n_up    = 1'b0;
                                n_bs    = 1'b1;
                            end else begin
                                // The cell before the cursor is one linear address back.
                                o_we    = 1'b1;
                                o_waddr = cur_addr - AW'(1);
                                o_wdata = {i_text_color, tccw_pkg::SPACE_CHAR};
                                if (r_col == '0) begin
                                    n_col = LAST_COL;
                                    n_row = r_row - RW'(1);
                                end else begin
                                    n_col = r_col - CW'(1);
                                end
                            end
                        end
                        tccw_pkg::ACT_SCROLL: begin
                            if (i_item.scroll_sign == tccw_pkg::SCROLL_UP) begin
                                n_state = tccw_pkg::ST_COPY;
                                n_up    = 1'b1;
                            end else if (i_item.scroll_sign[tccw_pkg::SIGN_W-1]) begin
                                n_state = tccw_pkg::ST_COPY;
                                n_up    = 1'b0;
                            end
                        end
                        tccw_pkg::ACT_PUT_AT: begin
                            o_we    = item_in_range;
                            o_waddr = item_addr;
                            o_wdata = {i_item.color_attr, i_item.char_code};
                        end
                        tccw_pkg::ACT_CLEAR: begin
                            n_state = tccw_pkg::ST_FILL;
                            n_end   = LAST_CELL;
                            n_fill  = {i_text_color, tccw_pkg::SPACE_CHAR};
                            n_row   = '0;
                            n_col   = '0;
                        end
                        tccw_pkg::ACT_READ_CELL: begin
                            o_re     = item_in_range;
                            o_raddr  = item_addr;
                            n_rd_hit = item_in_range;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            tccw_pkg::ST_COPY: begin
                // Read one cell per cycle, write it one row away in the next cycle.
                if (r_wvld) begin
                    o_we    = 1'b1;
                    o_waddr = r_wdst;
                    o_wdata = i_rdata;
                end
                if (r_cnt != NCOPY) begin
                    o_re    = 1'b1;
                    o_raddr = r_up ? (r_cnt + COL_STEP) : (DOWN_SRC0 - r_cnt);
                    n_wdst  = r_up ? r_cnt : (LAST_CELL - r_cnt);
                    n_wvld  = 1'b1;
                    n_cnt   = r_cnt + AW'(1);
                end else begin
                    n_wvld  = 1'b0;
                    n_state = tccw_pkg::ST_FILL;
                    n_cnt   = r_up ? LAST_BASE : '0;
                    n_end   = r_up ? LAST_CELL : LAST_ROW0;
                    n_fill  = tccw_pkg::BLANK_CELL;
                end
            end

            tccw_pkg::ST_FILL: begin
                o_we    = 1'b1;
                o_waddr = r_cnt;
                o_wdata = r_fill;
                if (r_cnt == r_end) begin
                    n_nores = 1'b0;
                    if (r_nores) begin
                        n_state = tccw_pkg::ST_IDLE;
                    end else if (r_bs) begin
                        n_state = tccw_pkg::ST_BLANK;
                    end else begin
                        n_state = tccw_pkg::ST_DONE;
                    end
                end else begin
                    n_cnt = r_cnt + AW'(1);
                end
            end

            tccw_pkg::ST_BLANK: begin
                o_we    = 1'b1;
                o_waddr = cur_addr;
                o_wdata = {i_text_color, tccw_pkg::SPACE_CHAR};
                n_bs    = 1'b0;
                n_state = tccw_pkg::ST_DONE;
            end

            tccw_pkg::ST_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = tccw_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = tccw_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_res.cursor_row = tccw_pkg::ROW_W'(r_row);
        o_res.cursor_col = tccw_pkg::COL_W'(r_col);
        o_res.cell_char  = r_rd_hit ? i_rdata[tccw_pkg::CHAR_W-1:0] : '0;
        o_res.cell_color = r_rd_hit ? i_rdata[tccw_pkg::CELL_W-1:tccw_pkg::CHAR_W] : '0;
    end

endmodule

// File: hdl/text_console_cell_writer.sv
`timescale 1ns / 1ps
// Put char, backspace, put cell at, read cell, a zero scroll and unused actions go from
// IDLE through DONE to the output register; scrolls and a put char that leaves the last
// row first run a row copy sweep and a one-row fill, backspace at the top-left also the
// BLANK state, clear a full-screen fill. Sweeps move one cell per cycle. No action is
// accepted until the result is in the output register, nor while reset (synchronous,
// active low) blanks all ROWS*COLUMNS cells to 0x0720, one per cycle.
module text_console_cell_writer #(
    parameter int COLUMNS = tccw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tccw_pkg::ROWS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration: text_color, written whenever the write enable is high.
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,
    // Action stream.
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // tdata: char_code[7:0], color_attr[15:8], scroll_sign[17:16], col[24:18],
    // row[29:25], zero[31:30].
    input  logic [31:0] i_s_axis_tdata,
    // tuser: action[2:0].
    input  logic [2:0]  i_s_axis_tuser,
    // Result stream.
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // tdata: cursor_row[4:0], cursor_col[11:5], cell_char[19:12], cell_color[27:20],
    // zero[31:28].
    output logic [31:0] o_m_axis_tdata
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);

    // Attribute byte for put char, backspace and clear.
    logic [tccw_pkg::ATTR_W-1:0] r_text_color;

    // Unpacked input transaction.
    tccw_pkg::t_item item;

    // Result handoff from the sequencer into the output register.
    tccw_pkg::t_result res;
    logic              res_valid;
    logic              res_ready;

    // Output register; it frees the sequencer from the downstream handshake.
    tccw_pkg::t_result r_out;
    logic              r_out_valid;

    // Screen memory port signals.
    logic                        mem_we;
    logic [AW-1:0]               mem_waddr;
    logic [tccw_pkg::CELL_W-1:0] mem_wdata;
    logic                        mem_re;
    logic [AW-1:0]               mem_raddr;
    logic [tccw_pkg::CELL_W-1:0] mem_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_color <= tccw_pkg::TEXT_COLOR_RST;
        end else if (i_cfg_we) begin
            r_text_color <= i_cfg_wdata;
        end
    end

    always_comb begin
        item.action      = i_s_axis_tuser;
        item.char_code   = i_s_axis_tdata[7:0];
        item.color_attr  = i_s_axis_tdata[15:8];
        item.scroll_sign = i_s_axis_tdata[17:16];
        item.col         = i_s_axis_tdata[24:18];
        item.row         = i_s_axis_tdata[29:25];
    end

    // The sequencer holds the cursor and walks the memory for scrolls and clears.
    tccw_ctrl #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_axis_tvalid),
        .o_ready      (o_s_axis_tready),
        .i_item       (item),
        .i_text_color (r_text_color),
        .o_res_valid  (res_valid),
        .i_res_ready  (res_ready),
        .o_res        (res),
        .o_we         (mem_we),
        .o_waddr      (mem_waddr),
        .o_wdata      (mem_wdata),
        .o_re         (mem_re),
        .o_raddr      (mem_raddr),
        .i_rdata      (mem_rdata)
    );

    // One 16-bit cell per screen position, row-major.
    tccw_ram #(
        .WIDTH (tccw_pkg::CELL_W),
        .DEPTH (CELLS)
    ) u_screen (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // The register takes a new result when it is empty or being drained this cycle.
    assign res_ready = !r_out_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {4'b0000, r_out};

endmodule

// File: hdl/tccw_checker.sv
`timescale 1ns / 1ps
// Port-level checks of text_console_cell_writer and the bind that attaches them.
// Depends on text_console_cell_writer and tccw_pkg.
module tccw_checker #(
    parameter int COLUMNS = tccw_pkg::COLUMNS_DEF
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [31:0] o_m_axis_tdata
);

    // A result that is not taken stays, unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("result changed or dropped while stalled");

    // Only one transaction is worked on at a time.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("input taken in back-to-back cycles");

    // The clearing pass after reset keeps the input closed.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_s_axis_tready)
        else $error("input open right after reset");

    // The reported cursor column lies on the screen and padding bits stay zero.
    a_cursor_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (32'(o_m_axis_tdata[11:5]) < COLUMNS)
                            && (o_m_axis_tdata[31:28] == 4'b0000))
        else $error("cursor column off screen or padding set");

endmodule

bind text_console_cell_writer tccw_checker #(
    .COLUMNS (COLUMNS)
) u_tccw_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for text_console_cell_writer: directed steps, then random phases.
// Depends on tccw_pkg for the action codes, the item and result layouts and the blank cell.
module tb_top;

    import tccw_pkg::*;

    // Screen geometry of the default build.
    localparam int SCR_COLS  = COLUMNS_DEF;
    localparam int SCR_ROWS  = ROWS_DEF;
    localparam int SCR_CELLS = SCR_COLS * SCR_ROWS;

    // Action codes that the block leaves unused.
    localparam logic [ACTION_W-1:0] ACT_SPARE_6 = 3'd6;
    localparam logic [ACTION_W-1:0] ACT_SPARE_7 = 3'd7;

    // Raw scroll_sign patterns beside the one the package names.
    localparam logic [SIGN_W-1:0] SCROLL_NONE     = 2'b00;
    localparam logic [SIGN_W-1:0] SCROLL_DOWN     = 2'b11;
    localparam logic [SIGN_W-1:0] SCROLL_DOWN_TWO = 2'b10;

    // The limit is many times the worst step, a scroll or clear, plus the longest receiver
    // hold-off, and also covers the blanking pass after reset.
    localparam int IDLE_LIMIT  = 20000;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASE_ITEMS = 70;
    localparam int PHASES      = 5;
    localparam int MAX_REPORTS = 10;

    // One row of the directed stimulus. When has_ref is set the expected result is
    // given by hand in ref_res instead of being computed.
    typedef struct {
        t_item   it;
        int      reps;
        bit      has_ref;
        t_result ref_res;
    } t_directed_step;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [7:0]  cfg_wdata = 8'h00;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = 32'h0;
    logic [2:0]  s_tuser   = 3'h0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;

    // Shadow copy of the console: screen, cursor and current text color.
    logic [CELL_W-1:0] shadow_screen [SCR_CELLS];
    logic [ROW_W-1:0]  shadow_row;
    logic [COL_W-1:0]  shadow_col;
    logic [ATTR_W-1:0] shadow_color;

    // Results still owed by the block, oldest first.
    t_result          cursor_reports_due[$];
    t_directed_step   directed_steps[$];

    int  mismatch_cnt = 0;
    int  idle_cycles  = 0;
    bit  tx_quiet     = 1'b0;
    bit  rx_quiet     = 1'b0;
    bit  hold_req     = 1'b0;

    text_console_cell_writer i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    initial begin
        forever begin
            #10 clk = ~clk;
        end
    end

    // ------------------------------------------------------------------
    // Console shadow model
    // ------------------------------------------------------------------

    function automatic void fill_screen(input logic [CELL_W-1:0] value);
        for (int i = 0; i < SCR_CELLS; i++) begin
            shadow_screen[i] = value;
        end
    endfunction

    // Content moves up one row; the bottom row becomes grey-on-black blanks.
    function automatic void roll_up();
        for (int i = 0; i + SCR_COLS < SCR_CELLS; i++) begin
            shadow_screen[i] = shadow_screen[i + SCR_COLS];
        end
        for (int i = 0; i < SCR_COLS; i++) begin
            shadow_screen[(SCR_ROWS - 1) * SCR_COLS + i] = BLANK_CELL;
        end
    endfunction

    // Content moves down one row; the top row becomes grey-on-black blanks.
    function automatic void roll_down();
        for (int i = SCR_CELLS - 1; i >= SCR_COLS; i--) begin
            shadow_screen[i] = shadow_screen[i - SCR_COLS];
        end
        for (int i = 0; i < SCR_COLS; i++) begin
            shadow_screen[i] = BLANK_CELL;
        end
    endfunction

    // Carriage return plus line feed; falling off the last row scrolls the screen.
    function automatic void advance_line();
        shadow_col = '0;
        if (int'(shadow_row) + 1 >= SCR_ROWS) begin
            roll_up();
            shadow_row = ROW_W'(SCR_ROWS - 1);
        end else begin
            shadow_row = shadow_row + 1'b1;
        end
    endfunction

    // Applies one action to the shadow console and returns the result it must produce.
    function automatic t_result console_apply(input t_item it);
        t_result res;
        bit      addr_ok;
        int      addr;
        res     = '0;
        addr_ok = (int'(it.col) < SCR_COLS) && (int'(it.row) < SCR_ROWS);
        addr    = int'(it.row) * SCR_COLS + int'(it.col);
        case (it.action)
            ACT_PUT_CHAR: begin
                if (it.char_code == NEWLINE_CHAR) begin
                    advance_line();
                end else begin
                    shadow_screen[int'(shadow_row) * SCR_COLS + int'(shadow_col)] =
                        {shadow_color, it.char_code};
                    shadow_col = shadow_col + 1'b1;
                    if (int'(shadow_col) >= SCR_COLS) begin
                        advance_line();
                    end
                end
            end
            ACT_BACKSPACE: begin
                // At column zero the cursor wraps to the end of the previous row; on the
                // top row the screen scrolls down instead.
                if (shadow_col == '0) begin
                    shadow_col = COL_W'(SCR_COLS - 1);
                    if (shadow_row == '0) begin
                        roll_down();
                    end else begin
                        shadow_row = shadow_row - 1'b1;
                    end
                end else begin
                    shadow_col = shadow_col - 1'b1;
                end
                shadow_screen[int'(shadow_row) * SCR_COLS + int'(shadow_col)] =
                    {shadow_color, SPACE_CHAR};
            end
            ACT_SCROLL: begin
                // Any negative pattern, -2 included, scrolls down by one row.
                if (it.scroll_sign == SCROLL_UP) begin
                    roll_up();
                end else if (it.scroll_sign[SIGN_W-1]) begin
                    roll_down();
                end
            end
            ACT_PUT_AT: begin
                if (addr_ok) begin
                    shadow_screen[addr] = {it.color_attr, it.char_code};
                end
            end
            ACT_CLEAR: begin
                fill_screen({shadow_color, SPACE_CHAR});
                shadow_row = '0;
                shadow_col = '0;
            end
            ACT_READ_CELL: begin
                if (addr_ok) begin
                    res.cell_char  = shadow_screen[addr][CHAR_W-1:0];
                    res.cell_color = shadow_screen[addr][CELL_W-1:CHAR_W];
                end
            end
            default: begin
            end
        endcase
        res.cursor_row = shadow_row;
        res.cursor_col = shadow_col;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Mostly back-to-back, often a short gap, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
            return 0;
        end else if (roll < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 50);
    endfunction

    task automatic add_step(input logic [ACTION_W-1:0] act, input logic [CHAR_W-1:0] ch,
                            input logic [ATTR_W-1:0] attr, input logic [SIGN_W-1:0] sgn,
                            input logic [COL_W-1:0] c, input logic [ROW_W-1:0] r,
                            input int reps, input bit has_ref,
                            input logic [ROW_W-1:0] e_row, input logic [COL_W-1:0] e_col,
                            input logic [CHAR_W-1:0] e_char, input logic [ATTR_W-1:0] e_attr);
        t_directed_step st;
        st.it.action       = act;
        st.it.char_code    = ch;
        st.it.color_attr   = attr;
        st.it.scroll_sign  = sgn;
        st.it.col          = c;
        st.it.row          = r;
        st.reps            = reps;
        st.has_ref         = has_ref;
        st.ref_res.cursor_row = e_row;
        st.ref_res.cursor_col = e_col;
        st.ref_res.cell_char  = e_char;
        st.ref_res.cell_color = e_attr;
        directed_steps.push_back(st);
    endtask

    // Random action, weighted so that text mostly flows forward and the cursor
    // reaches the bottom row, with scrolls and clears kept rare since they are slow.
    function automatic t_item random_action();
        t_item it;
        int    pick;
        it.char_code   = CHAR_W'($urandom_range(0, 255));
        it.color_attr  = ATTR_W'($urandom_range(0, 255));
        it.scroll_sign = SIGN_W'($urandom_range(0, 3));
        it.col         = COL_W'($urandom_range(0, 127));
        it.row         = ROW_W'($urandom_range(0, 31));
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            it.action = ACT_PUT_CHAR;
            if ($urandom_range(0, 7) == 0) begin
                it.char_code = NEWLINE_CHAR;
            end
        end else if (pick < 55) begin
            it.action = ACT_BACKSPACE;
        end else if (pick < 59) begin
            it.action = ACT_SCROLL;
        end else if (pick < 75) begin
            it.action = ACT_PUT_AT;
        end else if (pick < 77) begin
            it.action = ACT_CLEAR;
        end else if (pick < 95) begin
            it.action = ACT_READ_CELL;
        end else begin
            it.action = ($urandom_range(0, 1) == 0) ? ACT_SPARE_6 : ACT_SPARE_7;
        end
        // Most addressed actions hit the screen; the rest probe out-of-range addresses.
        if ((it.action == ACT_PUT_AT || it.action == ACT_READ_CELL) &&
            $urandom_range(0, 9) != 0) begin
            it.col = COL_W'($urandom_range(0, SCR_COLS - 1));
            it.row = ROW_W'($urandom_range(0, SCR_ROWS - 1));
        end
        return it;
    endfunction

    // Offers one action and waits for its transaction. tvalid is only lowered when a gap
    // is taken, so a back-to-back item never sees tvalid dropped and raised in one step.
    task automatic offer_item(input t_item it, input bit has_ref, input t_result ref_res);
        int      gap;
        t_result want;
        gap = tx_quiet ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, it.row, it.col, it.scroll_sign, it.color_attr, it.char_code};
        s_tuser  <= it.action;
        do begin
            @(posedge clk);
        end while (!s_tready);
        want = console_apply(it);
        cursor_reports_due.push_back(has_ref ? ref_res : want);
    endtask

    // Waits until every owed result has come back, then lets the block settle.
    task automatic drain_results();
        while (cursor_reports_due.size() != 0) begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Result side: backpressure and checking
    // ------------------------------------------------------------------

    // The receiver stalls at random, holds off for a long stretch on request, and
    // never stalls while rx_quiet is set.
    initial begin
        int stall;
        int run;
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                stall    = HOLD_CYCLES;
            end else begin
                stall = rx_quiet ? 0 : pick_gap();
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            run = $urandom_range(1, 16);
            repeat (run) @(posedge clk);
        end
    end

    // Every result transaction is compared with the oldest owed result.
    always @(posedge clk) begin
        t_result got;
        t_result want;
        if (rst_n && m_tvalid && m_tready) begin
            got = t_result'(m_tdata[27:0]);
            if (cursor_reports_due.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= MAX_REPORTS) begin
                    $display("unexpected result: row %0d col %0d char %02h attr %02h",
                             got.cursor_row, got.cursor_col, got.cell_char, got.cell_color);
                end
            end else begin
                want = cursor_reports_due.pop_front();
                if (got.cursor_row !== want.cursor_row || got.cursor_col !== want.cursor_col ||
                    got.cell_char !== want.cell_char || got.cell_color !== want.cell_color) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= MAX_REPORTS) begin
                        $display("mismatch: expected row %0d col %0d char %02h attr %02h",
                                 want.cursor_row, want.cursor_col, want.cell_char,
                                 want.cell_color);
                        $display("          actual   row %0d col %0d char %02h attr %02h",
                                 got.cursor_row, got.cursor_col, got.cell_char,
                                 got.cell_color);
                    end
                end
            end
        end
    end

    // Watchdog: any cycle with a transaction on either side resets the count.
    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
                $display("text_console_cell_writer regression: fail");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial begin
        t_directed_step st;
        logic [7:0]     color;
        fill_screen(BLANK_CELL);
        shadow_row   = '0;
        shadow_col   = '0;
        shadow_color = TEXT_COLOR_RST;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed steps. Hand-written expectations cover the reset screen, range
        // extremes and cursor wrap points; the rest come from the shadow model.
        // Reset screen, then an address with every bit set (out of range).
        add_step(ACT_READ_CELL, 8'h00, 8'h00, SCROLL_NONE, 7'd0, 5'd0, 1, 1'b1,
                 5'd0, 7'd0, SPACE_CHAR, GREY_ON_BLACK);
        add_step(ACT_READ_CELL, 8'h00, 8'h00, SCROLL_NONE, 7'd127, 5'd31, 1, 1'b1,
                 5'd0, 7'd0, 8'h00, 8'h00);
        // Character extremes and a read-back of the first one.
        add_step(ACT_PUT_CHAR, 8'h41, 8'h00, SCROLL_NONE, 7'd0, 5'd0, 1, 1'b1,
                 5'd0, 7'd1, 8'h00, 8'h00);
        add_step(ACT_PUT_CHAR, 8'hFF, 8'hFF, SCROLL_DOWN, 7'd127, 5'd31, 1, 1'b1,
                 5'd0, 7'd2, 8'h00, 8'h00);
        add_step(ACT_PUT_CHAR, 8'h00, 8'h00, SCROLL_NONE, 7'd0, 5'd0, 1, 1'b1,
                 5'd0, 7'd3, 8'h00, 8'h00);
        add_step(ACT_READ_CELL, 8'h00, 8'h00, SCROLL_NONE, 7'd0, 5'd0, 1, 1'b1,
                 5'd0, 7'd3, 8'h41, GREY_ON_BLACK);
        // Newline, then backspace at column zero wraps to the end of row 0.
        add_step(ACT_PUT_CHAR, NEWLINE_CHAR, 8'h00, SCROLL_NONE, 7'd0, 5'd0, 1, 1'b1,
                 5'd1, 7'd0, 8'h00, 8'h00);
        add_step(ACT_BACKSPACE, 8'h00, 8'h00, SCROLL_NONE, 7'd0, 5'd0, 1, 1'b1,
                 5'd0, 7'd79, 8'h00, 8'h00);
        add_step(ACT_BACKSPACE, 8'hFF, 8'hFF, SCROLL_DOWN, 7'd127, 5'd31, 1, 1'b1,
                 5'd0, 7'd78, 8'h00, 8'h00);
        // Direct write at the bottom-right corner, and out-of-range writes and reads.
        add_step(ACT_PUT_AT, 8'hFF, 8'hFF, SCROLL_NONE, 7'd79, 5'd23, 1, 1'b1,
                 5'd0, 7'd78, 8'h00, 8'h00);
        add_step(ACT_READ_CELL, 8'h00, 8'h00, SCROLL_NONE, 7'd79, 5'd23, 1, 1'b1,
                 5'd0, 7'd78, 8'hFF, 8'hFF);
        add_step(ACT_PUT_AT, 8'h55, 8'h55, SCROLL_NONE, 7'd80, 5'd0, 1, 1'b1,
                 5'd0, 7'd78, 8'h00, 8'h00);
        add_step(ACT_READ_CELL, 8'h00, 8'h00, SCROLL_NONE, 7'd80, 5'd0, 1, 1'b1,
                 5'd0, 7'd78, 8'h00, 8'h00);
        add_step(ACT_READ_CELL, 8'h00, 8'h00, SCROLL_NONE, 7'd0, 5'd24, 1, 1'b1,
                 5'd0, 7'd78, 8'h00, 8'h00);
        // Scroll up moves the corner cell to row 22; then every sign pattern.
        add_step(ACT_SCROLL, 8'h00, 8'h00, SCROLL_UP, 7'd0, 5'd0, 1, 1'b0,
                 5'd0, 7'd0, 8'h00, 8'h00);
        add_step(ACT_READ_CELL, 8'h00, 8'h00, SCROLL_NONE, 7'd79, 5'd22, 1, 1'b1,
                 5'd0, 7'd78, 8'hFF, 8'hFF);
        add_step(ACT_SCROLL, 8'h00, 8'h00, SCROLL_DOWN, 7'd0, 5'd0, 1, 1'b0,
                 5'd0, 7'd0, 8'h00, 8'h00);
        add_step(ACT_SCROLL, 8'h00, 8'h00, SCROLL_DOWN_TWO, 7'd0, 5'd0, 1, 1'b0,
                 5'd0, 7'd0, 8'h00, 8'h00);
        add_step(ACT_SCROLL, 8'h00, 8'h00, SCROLL_NONE, 7'd0, 5'd0, 1, 1'b0,
                 5'd0, 7'd0, 8'h00, 8'h00);
        // Unused actions change nothing, even with every field bit set.
        add_step(ACT_SPARE_6, 8'hFF, 8'hFF, SCROLL_DOWN, 7'd127, 5'd31, 1, 1'b1,
                 5'd0, 7'd78, 8'h00, 8'h00);
        add_step(ACT_SPARE_7, 8'h00, 8'h00, SCROLL_NONE, 7'd0, 5'd0, 1, 1'b1,
                 5'd0, 7'd78, 8'h00, 8'h00);
        // Clear, backspace at top-left (scrolls down), then line overflow.
        add_step(ACT_CLEAR, 8'h00, 8'h00, SCROLL_NONE, 7'd0, 5'd0, 1, 1'b1,
                 5'd0, 7'd0, 8'h00, 8'h00);
        add_step(ACT_BACKSPACE, 8'h00, 8'h00, SCROLL_NONE, 7'd0, 5'd0, 1, 1'b1,
                 5'd0, 7'd79, 8'h00, 8'h00);
        add_step(ACT_PUT_CHAR, 8'h5A, 8'h00, SCROLL_NONE, 7'd0, 5'd0, 1, 1'b1,
                 5'd1, 7'd0, 8'h00, 8'h00);
        // Enough newlines to leave the last row once, which scrolls the screen up.
        add_step(ACT_PUT_CHAR, NEWLINE_CHAR, 8'h00, SCROLL_NONE, 7'd0, 5'd0, 23, 1'b0,
                 5'd0, 7'd0, 8'h00, 8'h00);
        add_step(ACT_READ_CELL, 8'h00, 8'h00, SCROLL_NONE, 7'd0, 5'd0, 1, 1'b0,
                 5'd0, 7'd0, 8'h00, 8'h00);

        foreach (directed_steps[i]) begin
            st = directed_steps[i];
            for (int n = 0; n < st.reps; n++) begin
                offer_item(st.it, st.has_ref, st.ref_res);
            end
        end
        s_tvalid <= 1'b0;

        // Random phases, each under its own text color. The color only changes once
        // the block has answered everything. Phase 1 applies a long receiver hold-off
        // while the sender keeps pushing; phase 2 runs with no idling on either side.
        for (int ph = 0; ph < PHASES; ph++) begin
            drain_results();
            case (ph)
                0:       color = 8'hFF;
                1:       color = 8'h00;
                default: color = 8'($urandom_range(0, 255));
            endcase
            cfg_we    <= 1'b1;
            cfg_wdata <= color;
            @(posedge clk);
            cfg_we       <= 1'b0;
            shadow_color  = color;

            tx_quiet = (ph == 2);
            rx_quiet = (ph == 2);
            if (ph == 1) begin
                hold_req = 1'b1;
                tx_quiet = 1'b1;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 1 && n == 30) begin
                    tx_quiet = 1'b0;
                end
                offer_item(random_action(), 1'b0, '0);
            end
            s_tvalid <= 1'b0;
        end

        drain_results();
        rx_quiet = 1'b0;
        repeat (20) @(posedge clk);
        if (mismatch_cnt == 0) begin
            $display("text_console_cell_writer regression: pass");
        end else begin
            $display("text_console_cell_writer regression: fail");
        end
        $finish;
    end

endmodule

// File: text_console_cell_writer.f
hdl/tccw_pkg.sv
hdl/tccw_ram.sv
hdl/tccw_ctrl.sv
hdl/text_console_cell_writer.sv
hdl/tccw_checker.sv
tb/tb_top.sv
